@@ hw/rtl/roc_pkg.sv @@
// Package for the read overlap classifier: record types, codes and compare helpers.
package roc_pkg;

  localparam int POS_W    = 24;
  localparam int POS_BITS = 24;
  localparam int TOL_W    = 16;
  localparam int OVH_W    = 25;
  localparam int SVAL_W   = POS_W + 3;
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 112;

  localparam logic [POS_W-1:0] POS_MASK =
    (POS_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((64'd1 << POS_BITS) - 64'd1);

  localparam logic CFG_POS_TOL = 1'b0;
  localparam logic CFG_END_TOL = 1'b1;

  typedef logic signed [SVAL_W-1:0] sval_t;
  typedef logic signed [OVH_W-1:0]  ovh_t;

  typedef enum logic [2:0] {
    LOC_LEFT       = 3'd0,
    LOC_RIGHT      = 3'd1,
    LOC_EQUAL      = 3'd2,
    LOC_CONTAINING = 3'd3,
    LOC_CONTAINED  = 3'd4,
    LOC_ABNORMAL   = 3'd5
  } loc_t;

  typedef enum logic [1:0] {
    MARK_NONE  = 2'd0,
    MARK_LEFT  = 2'd1,
    MARK_RIGHT = 2'd2,
    MARK_BOTH  = 2'd3
  } mark_t;

  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2
  } cmp_t;

  localparam ovh_t OVH_NONE = '1;

  typedef struct packed {
    logic             b_strand;
    logic [POS_W-1:0] b_len;
    logic [POS_W-1:0] b_end;
    logic [POS_W-1:0] b_start;
    logic             a_strand;
    logic [POS_W-1:0] a_len;
    logic [POS_W-1:0] a_end;
    logic [POS_W-1:0] a_start;
  } in_rec_t;

  typedef struct packed {
    mark_t end_mark_b;
    mark_t end_mark_a;
    ovh_t  best_overhang_b;
    ovh_t  best_overhang_a;
    logic  ends_reach;
    ovh_t  class_overhang_b;
    ovh_t  class_overhang_a;
    loc_t  location_seen;
    loc_t  location;
  } out_rec_t;

  function automatic sval_t pos_val(input logic [POS_W-1:0] v);
    return sval_t'({3'b000, v & POS_MASK});
  endfunction

  function automatic cmp_t cmp_tol(input sval_t x, input sval_t y, input sval_t tol);
    cmp_t r;
    if (x < y - tol) r = CMP_LT;
    else if (x > y + tol) r = CMP_GT;
    else r = CMP_EQ;
    return r;
  endfunction

  function automatic sval_t max2(input sval_t x, input sval_t y);
    return (x > y) ? x : y;
  endfunction

endpackage

@@ hw/rtl/read_overlap_classifier.sv @@
// Read overlap classifier: classes, overhangs, end reach and end marks per record.
//
// Input channel in_*: one overlap record per transfer. in_tdata carries the spans,
// lengths and strands of reads A and B; in_tuser asks for the class seen from B.
// Output channel out_*: one result record per input record, in order.
// Configuration: cfg_wr_en writes cfg_wdata to the tolerance picked by cfg_index
// (0 position tolerance, 1 end tolerance). Write only while the block is idle.
//
// An input transfer reaches out_tvalid through an input register, one level of
// compares, subtracts and a min of four, then the result register.
// Throughput is one record per cycle while out_tready is high; each stage holds on its own.
// When the receiver stalls, the result register holds and the input register
// fills; in_tready drops once both are full and rises in the cycle that
// out_tready frees the result register.
// Reset (rst_n low, synchronous) empties both stages and clears the tolerances
// to 0.
module read_overlap_classifier (
  input  logic                      clk,
  input  logic                      rst_n,
  // a_start, a_end, a_len, a_strand, b_start, b_end, b_len, b_strand, zero fill
  input  logic [roc_pkg::IN_DATA_W-1:0]  in_tdata,
  // view_from_b
  input  logic                      in_tuser,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // location, location_seen, class_overhang_a, class_overhang_b, ends_reach,
  // best_overhang_a, best_overhang_b, end_mark_a, end_mark_b, zero fill
  output logic [roc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [roc_pkg::TOL_W-1:0] cfg_wdata
);
  import roc_pkg::*;

  logic [TOL_W-1:0] ptol_r, etol_r;
  in_rec_t          s1_rec_r;
  logic             s1_view_r;
  logic             s1_valid_r;
  out_rec_t         out_rec_r, out_rec_nxt;
  logic             out_valid_r;
  logic             s2_ready, s1_ready;

  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptol_r <= '0;
      etol_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POS_TOL: ptol_r <= cfg_wdata;
        CFG_END_TOL: etol_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_rec_r  <= in_rec_t'(in_tdata[$bits(in_rec_t)-1:0]);
      s1_view_r <= in_tuser;
    end
  end

  sval_t as, ae, al, bs, be, bl, ptol, etol;
  sval_t a0, a1, b0, b1;
  sval_t oas, oae, obs, obe;
  sval_t coa, cob, boa, bob;
  sval_t cand0, cand1, cand2, cand3;
  cmp_t  sa, ea, sb, eb;
  logic  same;
  loc_t  loc, seen;
  logic  [1:0] pick;
  mark_t ma, mb;
  logic  reach;

  always_comb begin
    as   = pos_val(s1_rec_r.a_start);
    ae   = pos_val(s1_rec_r.a_end);
    al   = pos_val(s1_rec_r.a_len);
    bs   = pos_val(s1_rec_r.b_start);
    be   = pos_val(s1_rec_r.b_end);
    bl   = pos_val(s1_rec_r.b_len);
    ptol = sval_t'({{(SVAL_W-TOL_W){1'b0}}, ptol_r});
    etol = sval_t'({{(SVAL_W-TOL_W){1'b0}}, etol_r});
    same = (s1_rec_r.a_strand == s1_rec_r.b_strand);

    sa = cmp_tol(as, '0, ptol);
    ea = cmp_tol(ae, al, ptol);
    sb = cmp_tol(bs, '0, ptol);
    eb = cmp_tol(be, bl, ptol);

    priority if (same && sa == CMP_GT && ea == CMP_EQ && sb == CMP_EQ && eb == CMP_LT)
      loc = LOC_LEFT;
    else if (same && sa == CMP_EQ && ea == CMP_LT && sb == CMP_GT && eb == CMP_EQ)
      loc = LOC_RIGHT;
    else if (!same && sa == CMP_EQ && ea == CMP_LT && sb == CMP_EQ && eb == CMP_LT)
      loc = LOC_LEFT;
    else if (!same && sa == CMP_GT && ea == CMP_EQ && sb == CMP_GT && eb == CMP_EQ)
      loc = LOC_RIGHT;
    else if (sa == CMP_EQ && ea == CMP_EQ && sb == CMP_EQ && eb == CMP_EQ)
      loc = LOC_EQUAL;
    else if (sa != CMP_LT && ea != CMP_GT && sb == CMP_EQ && eb == CMP_EQ)
      loc = LOC_CONTAINING;
    else if (sa == CMP_EQ && ea == CMP_EQ && sb != CMP_LT && eb != CMP_GT)
      loc = LOC_CONTAINED;
    else
      loc = LOC_ABNORMAL;

    seen = loc;
    if (s1_view_r) begin
      unique case (loc)
        LOC_LEFT:       seen = same ? LOC_RIGHT : LOC_LEFT;
        LOC_RIGHT:      seen = same ? LOC_LEFT : LOC_RIGHT;
        LOC_CONTAINING: seen = LOC_CONTAINED;
        LOC_CONTAINED:  seen = LOC_CONTAINING;
        default:        seen = loc;
      endcase
    end

    a0 = as;
    a1 = al - ae;
    b0 = bs;
    b1 = bl - be;

    coa = '1;
    cob = '1;
    unique case (loc)
      LOC_LEFT: begin
        coa = same ? a1 : a0;
        cob = b0;
      end
      LOC_RIGHT: begin
        coa = same ? a0 : a1;
        cob = b1;
      end
      LOC_CONTAINED:  coa = max2(a0, a1);
      LOC_CONTAINING: cob = max2(b0, b1);
      LOC_EQUAL: begin
        coa = max2(a0, a1);
        cob = max2(b0, b1);
      end
      default: ;
    endcase

    oas   = s1_rec_r.a_strand ? al - ae : as;
    oae   = s1_rec_r.a_strand ? al - as : ae;
    obs   = s1_rec_r.b_strand ? bl - be : bs;
    obe   = s1_rec_r.b_strand ? bl - bs : be;
    reach = !((oas > etol && obs > etol) || (oae < al - etol && obe < bl - etol));

    cand0 = same ? max2(a0, b1) : max2(a0, b0);
    cand1 = same ? max2(a1, b0) : max2(a1, b1);
    cand2 = max2(a0, a1);
    cand3 = max2(b0, b1);
    // ties keep the earlier candidate
    pick = 2'd0;
    if (cand1 < cand0) pick = 2'd1;
    if (cand2 < ((pick == 2'd1) ? cand1 : cand0)) pick = 2'd2;
    if (cand3 < ((pick == 2'd2) ? cand2 : (pick == 2'd1) ? cand1 : cand0)) pick = 2'd3;

    unique case (pick)
      2'd0: begin
        boa = a0;
        bob = same ? b1 : b0;
        ma  = MARK_LEFT;
        mb  = same ? MARK_RIGHT : MARK_LEFT;
      end
      2'd1: begin
        boa = a1;
        bob = same ? b0 : b1;
        ma  = MARK_RIGHT;
        mb  = same ? MARK_LEFT : MARK_RIGHT;
      end
      2'd2: begin
        boa = cand2;
        bob = '1;
        ma  = MARK_BOTH;
        mb  = MARK_NONE;
      end
      default: begin
        boa = '1;
        bob = cand3;
        ma  = MARK_NONE;
        mb  = MARK_BOTH;
      end
    endcase

    out_rec_nxt.location         = loc;
    out_rec_nxt.location_seen    = seen;
    out_rec_nxt.class_overhang_a = coa[OVH_W-1:0];
    out_rec_nxt.class_overhang_b = cob[OVH_W-1:0];
    out_rec_nxt.ends_reach       = reach;
    out_rec_nxt.best_overhang_a  = boa[OVH_W-1:0];
    out_rec_nxt.best_overhang_b  = bob[OVH_W-1:0];
    out_rec_nxt.end_mark_a       = ma;
    out_rec_nxt.end_mark_b       = mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_rec_r <= out_rec_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-$bits(out_rec_t)){1'b0}}, out_rec_r};

`ifndef SYNTHESIS
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid_r)
    else $error("accepted record missing from input stage");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> out_valid_r)
    else $error("input stage advanced without a result");

  a_abnormal_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rec_r.location == LOC_ABNORMAL) |->
    (out_rec_r.class_overhang_a == OVH_NONE && out_rec_r.class_overhang_b == OVH_NONE))
    else $error("abnormal class with class overhang");
`endif

endmodule
